// File: rtl/core/bspv_pkg.sv
// Shared types, constants and the arctangent lookup table for the brightest-spot polar vector block.
package bspv_pkg;

  localparam int MAX_DIM_DEF      = 4096;
  localparam int CORDIC_ITERS_DEF = 16;

  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;
  localparam int PIX_W   = 8;
  localparam int DIST_W  = 16;
  localparam int HEAD_W  = 15;
  localparam int OUT_W   = 64;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  // square root datapath: n = (dx^2 + dy^2) * 256 < 2^33
  localparam int SQ_ACC_W = 2 * CNT_W + 1;
  localparam int SQ_W     = 34;
  localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << 32;

  // CORDIC datapath
  localparam int CX_W       = 40;
  localparam int CX_SH      = 24;
  localparam int Z_W        = 26;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [Z_W-1:0] Z_90  = 26'sd5898240;
  localparam logic [Z_W-1:0]        A_180 = 26'd11796480;
  localparam logic [Z_W-1:0]        A_360 = 26'd23592960;
  localparam logic [Z_W-1:0]        A_RND = 26'd512;
  localparam int                    A_SH  = 10;

  localparam logic [HEAD_W-1:0] HEAD_0    = 15'd0;
  localparam logic [HEAD_W-1:0] HEAD_90   = 15'd5760;
  localparam logic [HEAD_W-1:0] HEAD_180  = 15'd11520;
  localparam logic [HEAD_W-1:0] HEAD_270  = 15'd17280;
  localparam logic [HEAD_W:0]   HEAD_FULL = 16'd23040;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT,
    ST_CORDIC,
    ST_FINISH
  } state_t;

  // arctangent of 2^-i in units of 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    begin
      case (idx)
        5'd0:    v = 26'sd2949120;
        5'd1:    v = 26'sd1740967;
        5'd2:    v = 26'sd919879;
        5'd3:    v = 26'sd466945;
        5'd4:    v = 26'sd234379;
        5'd5:    v = 26'sd117304;
        5'd6:    v = 26'sd58666;
        5'd7:    v = 26'sd29335;
        5'd8:    v = 26'sd14668;
        5'd9:    v = 26'sd7334;
        5'd10:   v = 26'sd3667;
        5'd11:   v = 26'sd1833;
        5'd12:   v = 26'sd917;
        5'd13:   v = 26'sd458;
        5'd14:   v = 26'sd229;
        5'd15:   v = 26'sd115;
        5'd16:   v = 26'sd57;
        5'd17:   v = 26'sd29;
        5'd18:   v = 26'sd14;
        5'd19:   v = 26'sd7;
        5'd20:   v = 26'sd4;
        5'd21:   v = 26'sd2;
        5'd22:   v = 26'sd1;
        default: v = 26'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: rtl/core/brightest_spot_polar_vector_top.sv
// Brightest-spot locator with polar offset (distance, heading) from the frame centre.
// Pixels: one per cycle while idle. The last pixel of a frame starts the vector math and
// in_tready stays low until it ends: squaring of dx and then dy on one shared multiplier,
// the square root (one result bit per step), the CORDIC vectoring iterations (skipped on
// an axis) and a finish step that waits until the previous result has been taken.
// Reset (rst_n low, synchronous): frame size 640x480, counters and best spot zero, no result.
module brightest_spot_polar_vector_top #(
  parameter int MAX_DIM      = bspv_pkg::MAX_DIM_DEF,
  parameter int CORDIC_ITERS = bspv_pkg::CORDIC_ITERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bspv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bspv_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bspv_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [11:0] spot_col, [23:12] spot_row, [31:24] spot_level, [47:32] distance,
  // [62:48] heading, [63] zero
  output logic [bspv_pkg::OUT_W-1:0]     out_tdata
);

  localparam int IT_W = $clog2(CORDIC_ITERS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_ITERS - 1);
  localparam logic [bspv_pkg::DIM_W-1:0] MAX_DIM_V = bspv_pkg::DIM_W'(MAX_DIM);

  localparam int CNT_W = bspv_pkg::CNT_W;
  localparam int DIM_W = bspv_pkg::DIM_W;
  localparam int SQ_W  = bspv_pkg::SQ_W;
  localparam int CX_W  = bspv_pkg::CX_W;
  localparam int Z_W   = bspv_pkg::Z_W;

  bspv_pkg::state_t state_r, state_nxt;

  logic [DIM_W-1:0]          width_r, height_r;
  logic [CNT_W-1:0]          col_r, row_r;
  logic [bspv_pkg::PIX_W-1:0] best_level_r;
  logic [CNT_W-1:0]          best_col_r, best_row_r;

  logic [CNT_W-1:0]          res_col_r, res_row_r;
  logic [bspv_pkg::PIX_W-1:0] res_level_r;
  logic [CNT_W-1:0]          ax_r, ay_r;
  logic                      dx_neg_r, dy_neg_r;

  logic [SQ_W-1:0]           rem_r, rem_nxt;
  logic [SQ_W-1:0]           root_r, root_nxt;
  logic [SQ_W-1:0]           bit_r, bit_nxt;

  logic signed [CX_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]     z_r, z_nxt;
  logic [IT_W-1:0]           iter_r, iter_nxt;

  logic                      out_valid_r;
  logic [bspv_pkg::OUT_W-1:0] out_data_r;

  // pixel path
  logic [DIM_W-1:0] w_c, h_c, w_m1, h_m1;
  logic [CNT_W-1:0] half_w, half_h;
  logic             in_fire, take, row_end, frame_end, axis;
  logic [CNT_W-1:0] bc, br;
  logic [bspv_pkg::PIX_W-1:0] bl;

  always_comb begin
    if (width_r == '0) w_c = DIM_W'(1);
    else if (width_r > MAX_DIM_V) w_c = MAX_DIM_V;
    else w_c = width_r;
    if (height_r == '0) h_c = DIM_W'(1);
    else if (height_r > MAX_DIM_V) h_c = MAX_DIM_V;
    else h_c = height_r;
  end

  assign w_m1      = w_c - DIM_W'(1);
  assign h_m1      = h_c - DIM_W'(1);
  assign half_w    = w_c[DIM_W-1:1];
  assign half_h    = h_c[DIM_W-1:1];
  assign in_fire   = in_tvalid && in_tready;
  assign take      = ((col_r == '0) && (row_r == '0)) || (in_tdata > best_level_r);
  assign bc        = take ? col_r : best_col_r;
  assign br        = take ? row_r : best_row_r;
  assign bl        = take ? in_tdata : best_level_r;
  assign row_end   = {1'b0, col_r} >= w_m1;
  assign frame_end = row_end && ({1'b0, row_r} >= h_m1);
  assign axis      = (ax_r == '0) || (ay_r == '0);

  // shared multiplier for the squares
  logic [CNT_W-1:0]     mul_in;
  logic [2*CNT_W-1:0]   prod;
  logic [bspv_pkg::SQ_ACC_W-1:0] sq_sum;

  assign mul_in = (state_r == bspv_pkg::ST_SQ_X) ? ax_r : ay_r;
  assign prod   = mul_in * mul_in;
  assign sq_sum = bspv_pkg::SQ_ACC_W'(rem_r) + bspv_pkg::SQ_ACC_W'(prod);

  // square root step
  logic [SQ_W-1:0] trial;
  assign trial = root_r + bit_r;

  // CORDIC step
  logic signed [CX_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atan_v;
  logic                   y_pos;
  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign atan_v = bspv_pkg::atan_entry(bspv_pkg::ATAN_IDX_W'(iter_r));
  assign y_pos  = !y_r[CX_W-1] && (y_r != '0);

  // heading and distance
  logic [Z_W-1:0]    zc, ang, ang_rnd;

  logic [bspv_pkg::HEAD_W:0]   ang_q;
  logic [bspv_pkg::HEAD_W-1:0] head;
  logic [SQ_W-1:0]             dist_full;
  logic [bspv_pkg::DIST_W-1:0] dist_q;

  always_comb begin
    if (z_r[Z_W-1]) zc = '0;
    else if (z_r > bspv_pkg::Z_90) zc = Z_W'(bspv_pkg::Z_90);
    else zc = z_r;
    if (!dx_neg_r && !dy_neg_r) ang = zc;
    else if (dx_neg_r && !dy_neg_r) ang = bspv_pkg::A_180 - zc;
    else if (dx_neg_r) ang = bspv_pkg::A_180 + zc;
    else ang = bspv_pkg::A_360 - zc;
    ang_rnd = ang + bspv_pkg::A_RND;
    ang_q = ang_rnd[bspv_pkg::A_SH +: bspv_pkg::HEAD_W + 1];
    if (ang_q >= bspv_pkg::HEAD_FULL) ang_q = ang_q - bspv_pkg::HEAD_FULL;
    if (ax_r == '0 && ay_r == '0) head = bspv_pkg::HEAD_0;
    else if (ay_r == '0) head = dx_neg_r ? bspv_pkg::HEAD_180 : bspv_pkg::HEAD_0;
    else if (ax_r == '0) head = dy_neg_r ? bspv_pkg::HEAD_270 : bspv_pkg::HEAD_90;
    else head = ang_q[bspv_pkg::HEAD_W-1:0];
    dist_full = root_r + SQ_W'(rem_r > root_r);
    dist_q    = dist_full[bspv_pkg::DIST_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bspv_pkg::ST_IDLE:   if (in_fire && frame_end) state_nxt = bspv_pkg::ST_SQ_X;
      bspv_pkg::ST_SQ_X:   state_nxt = bspv_pkg::ST_SQ_Y;
      bspv_pkg::ST_SQ_Y:   state_nxt = bspv_pkg::ST_ROOT;
      bspv_pkg::ST_ROOT:   if (bit_r[0]) state_nxt = axis ? bspv_pkg::ST_FINISH
                                                          : bspv_pkg::ST_CORDIC;
      bspv_pkg::ST_CORDIC: if (iter_r == IT_LAST) state_nxt = bspv_pkg::ST_FINISH;
      bspv_pkg::ST_FINISH: if (!out_valid_r) state_nxt = bspv_pkg::ST_IDLE;
      default:             state_nxt = bspv_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    iter_nxt = iter_r;
    unique case (state_r)
      bspv_pkg::ST_SQ_X: rem_nxt = SQ_W'(prod);
      bspv_pkg::ST_SQ_Y: begin
        rem_nxt  = SQ_W'({sq_sum, 8'd0});
        root_nxt = '0;
        bit_nxt  = bspv_pkg::SQ_BIT_INIT;
      end
      bspv_pkg::ST_ROOT: begin
        if (rem_r >= trial) begin
          rem_nxt  = rem_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        x_nxt    = CX_W'({ax_r, 24'd0});
        y_nxt    = CX_W'({ay_r, 24'd0});
        z_nxt    = '0;
        iter_nxt = '0;
      end
      bspv_pkg::ST_CORDIC: begin
        if (y_pos) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_v;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_v;
        end
        iter_nxt = iter_r + IT_W'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == bspv_pkg::ST_IDLE);
    cfg_ready  = 1'b1;
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bspv_pkg::ST_IDLE;
      width_r      <= bspv_pkg::WIDTH_RST;
      height_r     <= bspv_pkg::HEIGHT_RST;
      col_r        <= '0;
      row_r        <= '0;
      best_level_r <= '0;
      best_col_r   <= '0;
      best_row_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bspv_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
          bspv_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        best_level_r <= bl;
        best_col_r   <= bc;
        best_row_r   <= br;
        if (frame_end) begin
          col_r <= '0;
          row_r <= '0;
        end else if (row_end) begin
          col_r <= '0;
          row_r <= row_r + CNT_W'(1);
        end else begin
          col_r <= col_r + CNT_W'(1);
        end
      end
      if (state_r == bspv_pkg::ST_FINISH && !out_valid_r) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    iter_r <= iter_nxt;
    if (in_fire && frame_end) begin
      res_col_r   <= bc;
      res_row_r   <= br;
      res_level_r <= bl;
      dx_neg_r    <= bc < half_w;
      dy_neg_r    <= br < half_h;
      ax_r        <= (bc < half_w) ? half_w - bc : bc - half_w;
      ay_r        <= (br < half_h) ? half_h - br : br - half_h;
    end
    if (state_r == bspv_pkg::ST_FINISH && !out_valid_r) begin
      out_data_r <= {1'b0, head, dist_q, res_level_r, res_row_r, res_col_r};
    end
  end

`ifndef SYNTHESIS
  a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bspv_pkg::ST_ROOT |-> $onehot(bit_r))
    else $error("square root bit lost");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bspv_pkg::ST_CORDIC |-> iter_r <= IT_LAST)
    else $error("CORDIC iteration past last");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bspv_pkg::ST_FINISH && !out_valid_r |=>
      out_valid_r && state_r == bspv_pkg::ST_IDLE)
    else $error("finished result not presented");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[62:48]} < bspv_pkg::HEAD_FULL)
    else $error("heading out of range");
`endif

endmodule
